// ----- design/nlp_pkg.sv -----
// Shared types and constants for the numeric literal parser.
`timescale 1ns / 1ps

package nlp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned RADIX_N = 3;

   localparam int unsigned VALID_DEC = 0;
   localparam int unsigned VALID_HEX = 1;
   localparam int unsigned VALID_BIN = 2;

   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_B = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UPPER_H = 8'h48;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LOWER_H = 8'h68;

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Decoded character as handed from front to back.
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;   // zero when not a digit
      logic               bad;     // not a digit in any radix
      logic               ge10;    // not a decimal digit
      logic               ge2;     // not a binary digit
      logic               minus;
      logic               hex_sfx;
      logic               bin_sfx;
      logic               last;
   } nlp_class_type;

endpackage

// ----- design/nlp_req_if.sv -----
// Request channel interface: one character of the token per request.
`timescale 1ns / 1ps

interface nlp_req_if;
   logic                          valid;
   logic                          ready;
   logic [nlp_pkg::CHAR_W-1:0]    ch;
   logic                          last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

// ----- design/nlp_rsp_if.sv -----
// Response channel interface: parsed value and ok flag.
`timescale 1ns / 1ps

interface nlp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [nlp_pkg::VALUE_W-1:0] value;
   logic                               ok;

   modport source (output valid, output value, output ok, input ready);
   modport sink   (input valid, input value, input ok, output ready);
endinterface

// ----- design/numeric_literal_parser.sv -----
// Top level of the numeric literal parser.
//
//  channel  port     direction  payload
//  request  req_ch   in         ch[7:0], last
//  response rsp_ch   out        value[31:0] signed, ok
//
// One request per cycle while the queue has room; the back end retires one decoded
// character per cycle; a response is registered once its last character is popped.
// A two-entry queue parts the decoder from the accumulators; the response register
// holds one pending result, so only a last character waits on a stalled response.
// Synchronous active-high reset returns the parser to the start of a token.
`timescale 1ns / 1ps

module numeric_literal_parser (
   input  logic       clock,
   input  logic       reset,
   nlp_req_if.sink    req_ch,
   nlp_rsp_if.source  rsp_ch
);

   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_head_valid;
   nlp_pkg::nlp_class_type q_push_data;
   nlp_pkg::nlp_class_type q_head_data;

   nlp_front u_front (
      .req_ch (req_ch),
      .q_push (q_push),
      .q_data (q_push_data),
      .q_full (q_full)
   );

   nlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   nlp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ----- design/nlp_front.sv -----
// Front end: accepts characters and decodes them into digit classes.
`timescale 1ns / 1ps

module nlp_front (
   nlp_req_if.sink                 req_ch,
   output logic                    q_push,
   output nlp_pkg::nlp_class_type  q_data,
   input  logic                    q_full
);

   logic [nlp_pkg::CHAR_W-1:0] c;
   logic                       is_dec;
   logic                       is_lo;
   logic                       is_up;

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   always_comb begin
      c      = req_ch.ch;
      is_dec = (c >= nlp_pkg::CH_ZERO) && (c <= nlp_pkg::CH_NINE);
      is_lo  = (c >= nlp_pkg::CH_LOWER_A) && (c <= nlp_pkg::CH_LOWER_F);
      is_up  = (c >= nlp_pkg::CH_UPPER_A) && (c <= nlp_pkg::CH_UPPER_F);

      q_data.digit = '0;
      if (is_dec) begin
         q_data.digit = nlp_pkg::DIGIT_W'(c - nlp_pkg::CH_ZERO);
      end else if (is_lo) begin
         q_data.digit = nlp_pkg::DIGIT_W'(c - nlp_pkg::CH_LOWER_A + 8'd10);
      end else if (is_up) begin
         q_data.digit = nlp_pkg::DIGIT_W'(c - nlp_pkg::CH_UPPER_A + 8'd10);
      end
      q_data.bad     = !(is_dec || is_lo || is_up);
      q_data.ge10    = !is_dec;
      q_data.ge2     = !(is_dec && (c <= (nlp_pkg::CH_ZERO + 8'd1)));
      q_data.minus   = (c == nlp_pkg::CH_MINUS);
      q_data.hex_sfx = (c == nlp_pkg::CH_LOWER_H) || (c == nlp_pkg::CH_UPPER_H);
      q_data.bin_sfx = (c == nlp_pkg::CH_LOWER_B) || (c == nlp_pkg::CH_UPPER_B);
      q_data.last    = req_ch.last;
   end

endmodule

// ----- design/nlp_queue.sv -----
// Short queue of decoded characters between front and back.
`timescale 1ns / 1ps

module nlp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  nlp_pkg::nlp_class_type  push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output nlp_pkg::nlp_class_type  head_data
);

   nlp_pkg::nlp_class_type              entry_ff [nlp_pkg::Q_DEPTH];
   logic [nlp_pkg::Q_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [nlp_pkg::Q_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [nlp_pkg::Q_CNT_W-1:0]         count_ff, count_in;

   assign full       = (count_ff == nlp_pkg::Q_CNT_W'(nlp_pkg::Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == nlp_pkg::Q_PTR_W'(nlp_pkg::Q_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == nlp_pkg::Q_PTR_W'(nlp_pkg::Q_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/nlp_back.sv -----
// Back end: radix accumulators, result selection and output register.
`timescale 1ns / 1ps

module nlp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  nlp_pkg::nlp_class_type  head_data,
   output logic                    pop,
   nlp_rsp_if.source               rsp_ch
);

   localparam int unsigned VW = nlp_pkg::VALUE_W;

   logic                          at_start_ff, at_start_in;
   logic                          negative_ff, negative_in;
   logic [VW-1:0]                 acc_dec_ff, acc_dec_in;
   logic [VW-1:0]                 acc_hex_ff, acc_hex_in;
   logic [VW-1:0]                 acc_bin_ff, acc_bin_in;
   logic [nlp_pkg::RADIX_N-1:0]   radix_valid_ff, radix_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]          rsp_value_ff, rsp_value_in;
   logic                          rsp_ok_ff, rsp_ok_in;

   logic [VW-1:0]                 digit_ext;
   logic [VW-1:0]                 dec_next;
   logic [VW-1:0]                 hex_next;
   logic [VW-1:0]                 bin_next;
   logic [nlp_pkg::RADIX_N-1:0]   rv_next;
   logic                          out_free;
   logic                          good;
   logic [VW-1:0]                 acc_sel;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = rsp_value_ff;
   assign rsp_ch.ok    = rsp_ok_ff;

   always_comb begin
      digit_ext = VW'(head_data.digit);
      dec_next  = {acc_dec_ff[VW-4:0], 3'b000} + {acc_dec_ff[VW-2:0], 1'b0} + digit_ext;
      hex_next  = {acc_hex_ff[VW-1-nlp_pkg::DIGIT_W:0], head_data.digit};
      bin_next  = {acc_bin_ff[VW-2:0], 1'b0} + digit_ext;
      rv_next   = radix_valid_ff & ~{head_data.ge2, head_data.bad, head_data.ge10};

      out_free = !rsp_valid_ff || rsp_ch.ready;
      pop      = head_valid && (!head_data.last || out_free);

      at_start_in    = at_start_ff;
      negative_in    = negative_ff;
      acc_dec_in     = acc_dec_ff;
      acc_hex_in     = acc_hex_ff;
      acc_bin_in     = acc_bin_ff;
      radix_valid_in = radix_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_ok_in      = rsp_ok_ff;
      good           = 1'b0;
      acc_sel        = '0;

      if (head_data.hex_sfx) begin
         good    = !at_start_ff && radix_valid_ff[nlp_pkg::VALID_HEX];
         acc_sel = acc_hex_ff;
      end else if (head_data.bin_sfx) begin
         good    = !at_start_ff && radix_valid_ff[nlp_pkg::VALID_BIN];
         acc_sel = acc_bin_ff;
      end else if (at_start_ff && head_data.minus) begin
         good    = 1'b1;
         acc_sel = '0;
      end else begin
         good    = rv_next[nlp_pkg::VALID_DEC];
         acc_sel = dec_next;
      end

      if (pop && !head_data.last) begin
         at_start_in = 1'b0;
         if (at_start_ff && head_data.minus) begin
            negative_in = 1'b1;
         end else begin
            acc_dec_in     = dec_next;
            acc_hex_in     = hex_next;
            acc_bin_in     = bin_next;
            radix_valid_in = rv_next;
         end
      end else if (pop) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = good;
         rsp_value_in   = !good ? '0 : (negative_ff ? $signed(VW'(0) - acc_sel)
                                                    : $signed(acc_sel));
         at_start_in    = 1'b1;
         negative_in    = 1'b0;
         acc_dec_in     = '0;
         acc_hex_in     = '0;
         acc_bin_in     = '0;
         radix_valid_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff    <= 1'b1;
         negative_ff    <= 1'b0;
         acc_dec_ff     <= '0;
         acc_hex_ff     <= '0;
         acc_bin_ff     <= '0;
         radix_valid_ff <= '1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         at_start_ff    <= at_start_in;
         negative_ff    <= negative_in;
         acc_dec_ff     <= acc_dec_in;
         acc_hex_ff     <= acc_hex_in;
         acc_bin_ff     <= acc_bin_in;
         radix_valid_ff <= radix_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

`ifndef ASSERT_OFF
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_value_ff == '0))
      else $error("failed parse carries nonzero value");

   a_token_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head_data.last) |=> (at_start_ff && !negative_ff && (radix_valid_ff == '1)))
      else $error("state not cleared after last character");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !(pop && head_data.last))
      else $error("pending response overwritten");

   a_mid_token: assert property (@(posedge clock) disable iff (reset)
      (pop && !head_data.last) |=> (!at_start_ff && (rsp_valid_ff == $past(rsp_valid_in))))
      else $error("non-last character left token start set");
`endif

endmodule

// ----- sim/numeric_literal_parser_tb.sv -----
// Self-checking testbench for the numeric literal parser: directed tokens, then random tokens.
`timescale 1ns / 1ps

module numeric_literal_parser_tb;

   localparam int NOT_A_DIGIT = 16;
   localparam int RANDOM_ITEMS = 1850;

   typedef struct packed {
      logic signed [nlp_pkg::VALUE_W-1:0] value;
      logic                               ok;
   } parse_result_type;

   typedef struct packed {
      logic [nlp_pkg::CHAR_W-1:0]         ch;
      logic                               last;
      logic                               typed;
      logic signed [nlp_pkg::VALUE_W-1:0] value;
      logic                               ok;
   } token_step_type;

   localparam int N_DIRECTED = 24;
   localparam token_step_type DIRECTED [N_DIRECTED] = '{
      '{nlp_pkg::CH_ZERO,    1'b1, 1'b1, 32'sd0,  1'b1},
      '{nlp_pkg::CH_LOWER_H, 1'b1, 1'b1, 32'sd0,  1'b0},
      '{nlp_pkg::CH_UPPER_B, 1'b1, 1'b1, 32'sd0,  1'b0},
      '{nlp_pkg::CH_MINUS,   1'b1, 1'b1, 32'sd0,  1'b1},
      '{nlp_pkg::CH_MINUS,   1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_UPPER_H, 1'b1, 1'b1, 32'sd0,  1'b1},
      '{nlp_pkg::CH_UPPER_F, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_LOWER_F, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_UPPER_F, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_LOWER_F, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_UPPER_F, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_LOWER_F, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_UPPER_F, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_LOWER_F, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_LOWER_H, 1'b1, 1'b1, -32'sd1, 1'b1},
      '{nlp_pkg::CH_MINUS,   1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CHAR_W'(nlp_pkg::CH_ZERO + 1), 1'b0, 1'b0, 32'sd0, 1'b0},
      '{nlp_pkg::CH_LOWER_B, 1'b1, 1'b1, -32'sd1, 1'b1},
      '{nlp_pkg::CHAR_W'(nlp_pkg::CH_ZERO + 1), 1'b0, 1'b0, 32'sd0, 1'b0},
      '{nlp_pkg::CH_MINUS,   1'b1, 1'b1, 32'sd0,  1'b0},
      '{8'hff,               1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_ZERO,    1'b1, 1'b1, 32'sd0,  1'b0},
      '{nlp_pkg::CH_LOWER_B, 1'b0, 1'b0, 32'sd0,  1'b0},
      '{nlp_pkg::CH_LOWER_H, 1'b1, 1'b1, 32'sd11, 1'b1}
   };

   localparam logic [nlp_pkg::CHAR_W-1:0] SPECIAL_CHARS [5] = '{
      nlp_pkg::CH_MINUS, nlp_pkg::CH_LOWER_H, nlp_pkg::CH_UPPER_H,
      nlp_pkg::CH_LOWER_B, nlp_pkg::CH_UPPER_B
   };

   logic clock;
   logic reset;

   nlp_req_if req_ch ();
   nlp_rsp_if rsp_ch ();

   numeric_literal_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // parser state mirror
   logic                          at_start;
   logic                          negative;
   logic [nlp_pkg::VALUE_W-1:0]   acc_dec;
   logic [nlp_pkg::VALUE_W-1:0]   acc_hex;
   logic [nlp_pkg::VALUE_W-1:0]   acc_bin;
   logic [nlp_pkg::RADIX_N-1:0]   radix_ok;

   parse_result_type due_results [$];
   int errors;
   int items_sent;
   int tokens_sent;
   int results_seen;
   int ok_seen;
   int req_calm;
   int rsp_calm;
   int rsp_hold;
   bit rush;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int draw_gap(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) calm = $urandom_range(8, 40);
      return $urandom_range(0, 11);
   endfunction

   function automatic int digit_value(logic [nlp_pkg::CHAR_W-1:0] c);
      if (c >= nlp_pkg::CH_ZERO && c <= nlp_pkg::CH_NINE)
         return int'(c - nlp_pkg::CH_ZERO);
      if (c >= nlp_pkg::CH_LOWER_A && c <= nlp_pkg::CH_LOWER_F)
         return int'(c - nlp_pkg::CH_LOWER_A) + 10;
      if (c >= nlp_pkg::CH_UPPER_A && c <= nlp_pkg::CH_UPPER_F)
         return int'(c - nlp_pkg::CH_UPPER_A) + 10;
      return NOT_A_DIGIT;
   endfunction

   task automatic clear_parser();
      at_start = 1'b1;
      negative = 1'b0;
      acc_dec  = '0;
      acc_hex  = '0;
      acc_bin  = '0;
      radix_ok = '1;
   endtask

   task automatic absorb_digit(logic [nlp_pkg::CHAR_W-1:0] c);
      int d;
      d = digit_value(c);
      if (d >= 10) radix_ok[nlp_pkg::VALID_DEC] = 1'b0;
      if (d >= NOT_A_DIGIT) radix_ok[nlp_pkg::VALID_HEX] = 1'b0;
      if (d >= 2) radix_ok[nlp_pkg::VALID_BIN] = 1'b0;
      if (d >= NOT_A_DIGIT) d = 0;
      acc_dec = acc_dec * 10 + nlp_pkg::VALUE_W'(d);
      acc_hex = acc_hex * 16 + nlp_pkg::VALUE_W'(d);
      acc_bin = acc_bin * 2 + nlp_pkg::VALUE_W'(d);
   endtask

   task automatic parse_char(input logic [nlp_pkg::CHAR_W-1:0] c, input logic last,
                             output bit emits, output parse_result_type res);
      logic [nlp_pkg::VALUE_W-1:0] acc;
      logic                        good;
      emits = 1'b0;
      res   = '0;
      if (!last) begin
         if (at_start && c == nlp_pkg::CH_MINUS) negative = 1'b1;
         else absorb_digit(c);
         at_start = 1'b0;
      end else begin
         if (c == nlp_pkg::CH_LOWER_H || c == nlp_pkg::CH_UPPER_H) begin
            good = !at_start && radix_ok[nlp_pkg::VALID_HEX];
            acc  = acc_hex;
         end else if (c == nlp_pkg::CH_LOWER_B || c == nlp_pkg::CH_UPPER_B) begin
            good = !at_start && radix_ok[nlp_pkg::VALID_BIN];
            acc  = acc_bin;
         end else if (at_start && c == nlp_pkg::CH_MINUS) begin
            good = 1'b1;
            acc  = '0;
         end else begin
            absorb_digit(c);
            good = radix_ok[nlp_pkg::VALID_DEC];
            acc  = acc_dec;
         end
         if (good && negative) acc = -acc;
         if (!good) acc = '0;
         emits     = 1'b1;
         res.value = acc;
         res.ok    = good;
         clear_parser();
      end
   endtask

   task automatic send_char(input logic [nlp_pkg::CHAR_W-1:0] c, input logic last,
                            input logic typed,
                            input logic signed [nlp_pkg::VALUE_W-1:0] tv, input logic tok);
      int               gap;
      bit               emits;
      parse_result_type res;
      gap = rush ? 0 : draw_gap(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.ch    <= c;
      req_ch.last  <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      parse_char(c, last, emits, res);
      if (emits) begin
         if (typed) begin
            res.value = tv;
            res.ok    = tok;
         end
         due_results.push_back(res);
         tokens_sent++;
      end
      items_sent++;
   endtask

   function automatic logic [nlp_pkg::CHAR_W-1:0] radix_digit(int radix);
      int v;
      v = $urandom_range(0, radix - 1);
      if (v < 10) return nlp_pkg::CH_ZERO + nlp_pkg::CHAR_W'(v);
      return ($urandom_range(0, 1) ? nlp_pkg::CH_LOWER_A : nlp_pkg::CH_UPPER_A)
             + nlp_pkg::CHAR_W'(v - 10);
   endfunction

   task automatic send_random_token();
      logic [nlp_pkg::CHAR_W-1:0] chars [$];
      int                         kind;
      int                         len;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) chars.push_back(nlp_pkg::CH_MINUS);
      if (kind < 30) begin
         len = $urandom_range(1, 11);
         repeat (len) chars.push_back(radix_digit(10));
      end else if (kind < 55) begin
         len = $urandom_range(1, 9);
         repeat (len) chars.push_back(radix_digit(16));
         chars.push_back($urandom_range(0, 1) ? nlp_pkg::CH_LOWER_H : nlp_pkg::CH_UPPER_H);
      end else if (kind < 75) begin
         len = $urandom_range(1, 33);
         repeat (len) chars.push_back(radix_digit(2));
         chars.push_back($urandom_range(0, 1) ? nlp_pkg::CH_LOWER_B : nlp_pkg::CH_UPPER_B);
      end else if (kind < 88) begin
         len = $urandom_range(1, 8);
         repeat (len) chars.push_back(radix_digit(16));
         if ($urandom_range(0, 1)) chars.push_back(SPECIAL_CHARS[$urandom_range(1, 4)]);
         chars[$urandom_range(0, chars.size() - 1)] = nlp_pkg::CHAR_W'($urandom_range(0, 255));
      end else begin
         len = $urandom_range(1, 5);
         repeat (len) begin
            if ($urandom_range(0, 1))
               chars.push_back(nlp_pkg::CHAR_W'($urandom_range(0, 255)));
            else
               chars.push_back(SPECIAL_CHARS[$urandom_range(0, 4)]);
         end
      end
      foreach (chars[i])
         send_char(chars[i], i == chars.size() - 1, 1'b0, '0, 1'b0);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.ok === 1'b1) ok_seen++;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected response value=%0d ok=%b", $time,
                     rsp_ch.value, rsp_ch.ok);
         end else begin
            want = due_results.pop_front();
            if (rsp_ch.value !== want.value) begin
               errors++;
               $display("%0t: value expected %0d actual %0d", $time, want.value,
                        rsp_ch.value);
            end
            if (rsp_ch.ok !== want.ok) begin
               errors++;
               $display("%0t: ok expected %b actual %b", $time, want.ok, rsp_ch.ok);
            end
         end
      end
   end

   // response sink with random stalls and one long hold
   initial begin
      int stall;
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold > 0) begin
            n        = rsp_hold;
            rsp_hold = 0;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            stall = draw_gap(rsp_calm);
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
            while (!rsp_ch.valid && rsp_hold == 0) @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("[numeric_literal_parser] ERROR");
      $finish;
   end

   initial begin
      bit held;
      errors       = 0;
      items_sent   = 0;
      tokens_sent  = 0;
      results_seen = 0;
      ok_seen      = 0;
      req_calm     = 0;
      rsp_calm     = 0;
      rsp_hold     = 0;
      rush         = 1'b0;
      held         = 1'b0;
      clear_parser();
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.ch    <= '0;
      req_ch.last  <= 1'b0;
      rsp_ch.ready <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i])
         send_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed,
                   DIRECTED[i].value, DIRECTED[i].ok);

      while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
         if (!held && items_sent > N_DIRECTED + RANDOM_ITEMS / 2) begin
            // drain, then flood while the response side is held off
            held = 1'b1;
            wait_drained();
            rsp_hold = 300;
            rush     = 1'b1;
            repeat (30) send_random_token();
            rush = 1'b0;
         end else begin
            send_random_token();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Sent %0d characters in %0d tokens; %0d results checked, %0d of them valid.",
               items_sent, tokens_sent, results_seen, ok_seen);
      if (errors == 0)
         $display("[numeric_literal_parser] OK");
      else
         $display("[numeric_literal_parser] ERROR");
      $finish;
   end

endmodule
